// File: sv/fprt_pkg.sv
`default_nettype none
package fprt_pkg;

    localparam int MAX_TASKS = 16;
    localparam int TIME_BITS = 32;
    localparam int FRAC_BITS = 8;
    localparam int MAX_SPLIT = 16;

    localparam int TASK_W  = $clog2(MAX_TASKS);
    localparam int CNT_W   = 5;
    localparam int SPLIT_W = 5;
    localparam int CRIT_W  = 8;
    localparam int OUT_W   = 40;
    localparam int QW      = TIME_BITS + FRAC_BITS;   // fixed-point time
    localparam int PW      = QW + 1;                  // previous iterate
    localparam int RW      = 63;                      // saturating sums
    localparam int DW      = PW + SPLIT_W;            // divider dividend
    localparam int MW      = PW + 1;                  // serial multiplier operand
    localparam int PRW     = MW + QW;                 // full product
    localparam int ADDR_W  = 3;

    localparam logic [RW-1:0]    SATV    = {1'b1, {(RW-1){1'b0}}};
    localparam logic [OUT_W-1:0] OUT_MAX = {OUT_W{1'b1}};

    localparam logic [1:0] MODE_RM   = 2'd0;
    localparam logic [1:0] MODE_CRIT = 2'd1;
    localparam logic [1:0] MODE_PT   = 2'd2;

    localparam logic CMD_LOAD  = 1'b0;
    localparam logic CMD_QUERY = 1'b1;

    localparam logic REG_MODE  = 1'b0;
    localparam logic REG_COUNT = 1'b1;

    typedef struct packed {
        logic [TIME_BITS-1:0] nominal;
        logic [TIME_BITS-1:0] overload;
        logic [TIME_BITS-1:0] period;
        logic [CRIT_W-1:0]    crit;
        logic [SPLIT_W-1:0]   split;
        logic [TIME_BITS-1:0] companion;
    } t_entry;

    function automatic logic [SPLIT_W-1:0] eff_split(input logic [SPLIT_W-1:0] s);
        logic [SPLIT_W-1:0] r;
        r = s;
        if (s == '0) r = SPLIT_W'(1);
        else if (s > SPLIT_W'(MAX_SPLIT)) r = SPLIT_W'(MAX_SPLIT);
        return r;
    endfunction

    function automatic logic [TIME_BITS-1:0] eff_period(input logic [TIME_BITS-1:0] t);
        return (t == '0) ? TIME_BITS'(1) : t;
    endfunction

    function automatic logic [RW-1:0] sat_add(input logic [RW-1:0] a, input logic [RW-1:0] b);
        logic [RW:0] s;
        s = {1'b0, a} + {1'b0, b};
        return (s > {1'b0, SATV}) ? SATV : s[RW-1:0];
    endfunction

endpackage
`default_nettype wire

// File: sv/fixed_priority_response_time.sv
// Load beat: result in the cycle after acceptance (table write is immediate).
// Query beat: table read (plus the period transformation, two divisions, in PT mode), then per
// fixed-point iteration a pass over every table entry in use, with a division and a
// multiplication per interfering task (RM/criticality) plus two more divisions (PT), then the
// result is issued; all of it runs on the shared bit-serial divider and multiplier. One beat at a time.
// Reset is synchronous: control and config reset (mode to RM, count to 1), the task table is not cleared.
`default_nettype none
module fixed_priority_response_time
    import fprt_pkg::*;
(
    input  wire                    i_clk,
    input  wire                    i_rst_n,
    input  wire                    i_valid,
    output logic                   o_stall,
    input  wire                    i_cmd,
    input  wire  [3:0]             i_task_index,
    input  wire  [31:0]            i_nominal_exec_ns,
    input  wire  [31:0]            i_overload_exec_ns,
    input  wire  [31:0]            i_period_ns,
    input  wire  [7:0]             i_criticality_level,
    input  wire  [4:0]             i_split_count,
    input  wire  [31:0]            i_companion_exec_ns,
    output logic                   o_valid,
    input  wire                    i_stall,
    output logic [OUT_W-1:0]       o_response_q,
    output logic                   o_schedulable,
    output logic                   o_is_answer,
    input  wire                    psel,
    input  wire                    penable,
    input  wire                    pwrite,
    input  wire  [ADDR_W-1:0]      paddr,
    input  wire  [31:0]            pwdata,
    output logic [31:0]            prdata,
    output logic                   pready
);

    typedef enum logic [15:0] {
        S_IDLE    = 16'h0001,
        S_RSELF   = 16'h0002,
        S_SELF    = 16'h0004,
        S_OWN_DIV = 16'h0008,
        S_FIN_DIV = 16'h0010,
        S_ITER    = 16'h0020,
        S_RJ      = 16'h0040,
        S_JCHK    = 16'h0080,
        S_QDIV    = 16'h0100,
        S_MUL     = 16'h0200,
        S_CDIV    = 16'h0400,
        S_NDIV    = 16'h0800,
        S_LAST    = 16'h1000,
        S_NEXT    = 16'h2000,
        S_COND    = 16'h4000,
        S_DONE    = 16'h8000
    } t_state;

    t_state r_state;

    t_entry r_mem [MAX_TASKS];
    t_entry r_rd;

    logic [1:0]       r_mode;
    logic [CNT_W-1:0] r_count;

    logic [TASK_W-1:0]    r_self;
    logic [TIME_BITS-1:0] r_s_per, r_s_comp;
    logic [CRIT_W-1:0]    r_s_crit;
    logic [SPLIT_W-1:0]   r_s_n;
    logic [CNT_W-1:0]     r_j;

    logic [PW-1:0]  r_own, r_prev;
    logic [QW-1:0]  r_final, r_bound, r_rem;
    logic [RW-1:0]  r_resp;
    logic [SPLIT_W:0] r_arr;
    logic [QW+SPLIT_W:0] r_last;

    logic [DW-1:0]  r_dq;
    logic [QW-1:0]  r_dr, r_dv;
    logic [$clog2(DW+1)-1:0] r_dcnt;

    logic [MW-1:0]  r_ma;
    logic [QW-1:0]  r_mb;
    logic [PRW-1:0] r_macc;
    logic [$clog2(MW+1)-1:0] r_mcnt;

    logic r_ovalid, r_osched, r_oans;
    logic [OUT_W-1:0] r_oresp;

    logic in_acc, cfg_wr, out_free;
    logic [CNT_W-1:0] used;
    logic pt;

    // divider step
    logic [QW:0] d_trial, d_sub;
    logic        d_ge;

    // interferer view of the entry just read
    logic [SPLIT_W-1:0]   j_n;
    logic [QW-1:0]        j_tq, j_cq;
    logic [TIME_BITS+SPLIT_W-1:0] l_key, r_key;
    logic hit;
    logic [RW-1:0] prod_sat;
    logic [QW+SPLIT_W:0] last_min;

    assign pready   = 1'b1;
    assign cfg_wr   = psel && penable && pwrite;
    assign prdata   = (paddr[2] == REG_COUNT) ? 32'(r_count) : 32'(r_mode);
    assign out_free = !r_ovalid || !i_stall;
    assign o_stall  = (r_state != S_IDLE) || !out_free;
    assign in_acc   = i_valid && !o_stall;
    assign used     = (r_count > CNT_W'(MAX_TASKS)) ? CNT_W'(MAX_TASKS) : r_count;
    assign pt       = (r_mode == MODE_PT);

    assign o_valid       = r_ovalid;
    assign o_response_q  = r_oresp;
    assign o_schedulable = r_osched;
    assign o_is_answer   = r_oans;

    always_comb begin
        d_trial = {r_dr, r_dq[DW-1]};
        d_ge    = d_trial >= {1'b0, r_dv};
        d_sub   = d_trial - {1'b0, r_dv};

        j_n  = eff_split(r_rd.split);
        j_tq = {eff_period(r_rd.period), {FRAC_BITS{1'b0}}};
        j_cq = {r_rd.nominal, {FRAC_BITS{1'b0}}};

        l_key = eff_period(r_s_per) * j_n;
        r_key = eff_period(r_rd.period) * r_s_n;
        if (r_mode == MODE_CRIT) begin
            hit = (r_s_crit != r_rd.crit) ? (r_s_crit < r_rd.crit) : (l_key > r_key);
        end else begin
            hit = (l_key > r_key) || ((l_key == r_key) && (r_s_crit < r_rd.crit));
        end

        prod_sat = (r_macc > PRW'(SATV)) ? SATV : r_macc[RW-1:0];
        last_min = (r_last > (QW+SPLIT_W+1)'(j_cq)) ? (QW+SPLIT_W+1)'(j_cq) : r_last;
    end

    always_ff @(posedge i_clk) begin
        r_rd <= r_mem[r_j[TASK_W-1:0]];
        if (in_acc && i_cmd == CMD_LOAD) begin
            r_mem[i_task_index[TASK_W-1:0]] <= '{
                nominal:   i_nominal_exec_ns[TIME_BITS-1:0],
                overload:  i_overload_exec_ns[TIME_BITS-1:0],
                period:    i_period_ns[TIME_BITS-1:0],
                crit:      i_criticality_level,
                split:     i_split_count,
                companion: i_companion_exec_ns[TIME_BITS-1:0]
            };
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_mode   <= MODE_RM;
            r_count  <= CNT_W'(1);
            r_ovalid <= 1'b0;
            r_dcnt   <= '0;
            r_mcnt   <= '0;
            r_j      <= '0;
        end else begin
            if (cfg_wr) begin
                if (paddr[2] == REG_MODE) r_mode <= pwdata[1:0];
                else r_count <= pwdata[CNT_W-1:0];
            end
            if (r_ovalid && !i_stall) r_ovalid <= 1'b0;

            if (r_dcnt != '0) begin
                r_dq   <= {r_dq[DW-2:0], d_ge};
                r_dr   <= d_ge ? d_sub[QW-1:0] : d_trial[QW-1:0];
                r_dcnt <= r_dcnt - 1'b1;
            end
            if (r_mcnt != '0) begin
                r_macc <= {r_macc[PRW-2:0], 1'b0} + (r_ma[MW-1] ? PRW'(r_mb) : '0);
                r_ma   <= {r_ma[MW-2:0], 1'b0};
                r_mcnt <= r_mcnt - 1'b1;
            end

            case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        if (i_cmd == CMD_LOAD) begin
                            r_ovalid <= 1'b1;
                            r_oresp  <= '0;
                            r_osched <= 1'b0;
                            r_oans   <= 1'b0;
                        end else begin
                            r_self  <= i_task_index[TASK_W-1:0];
                            r_j     <= CNT_W'(i_task_index[TASK_W-1:0]);
                            r_state <= S_RSELF;
                        end
                    end
                end
                S_RSELF: r_state <= S_SELF;
                S_SELF: begin
                    r_s_per  <= r_rd.period;
                    r_s_comp <= r_rd.companion;
                    r_s_crit <= r_rd.crit;
                    r_s_n    <= eff_split(r_rd.split);
                    r_bound  <= {r_rd.period, {FRAC_BITS{1'b0}}};
                    if (pt) begin
                        r_dq    <= DW'({r_rd.overload, {FRAC_BITS{1'b0}}});
                        r_dr    <= '0;
                        r_dv    <= QW'(eff_split(r_rd.split));
                        r_dcnt  <= ($clog2(DW+1))'(DW);
                        r_state <= S_OWN_DIV;
                    end else begin
                        r_own   <= PW'({r_rd.overload, {FRAC_BITS{1'b0}}});
                        r_resp  <= RW'({r_rd.overload, {FRAC_BITS{1'b0}}});
                        r_final <= {r_rd.period, {FRAC_BITS{1'b0}}};
                        r_state <= S_ITER;
                    end
                end
                S_OWN_DIV: begin
                    if (r_dcnt == '0) begin
                        r_own  <= PW'(r_dq) + PW'({r_s_comp, {FRAC_BITS{1'b0}}});
                        r_resp <= RW'(r_dq) + RW'({r_s_comp, {FRAC_BITS{1'b0}}});
                        r_dq   <= DW'({r_s_per, {FRAC_BITS{1'b0}}});
                        r_dr   <= '0;
                        r_dv   <= QW'(r_s_n);
                        r_dcnt <= ($clog2(DW+1))'(DW);
                        r_state <= S_FIN_DIV;
                    end
                end
                S_FIN_DIV: begin
                    if (r_dcnt == '0) begin
                        r_final <= r_dq[QW-1:0];
                        r_state <= S_ITER;
                    end
                end
                S_ITER: begin
                    r_prev  <= r_resp[PW-1:0];
                    r_resp  <= RW'(r_own);
                    r_j     <= '0;
                    r_state <= S_RJ;
                end
                S_RJ: r_state <= (r_j >= used) ? S_COND : S_JCHK;
                S_JCHK: begin
                    if (r_j[TASK_W-1:0] == r_self || !hit) begin
                        r_state <= S_NEXT;
                    end else begin
                        r_dq    <= DW'(r_prev);
                        r_dr    <= '0;
                        r_dv    <= j_tq;
                        r_dcnt  <= ($clog2(DW+1))'(DW);
                        r_state <= S_QDIV;
                    end
                end
                S_QDIV: begin
                    if (r_dcnt == '0) begin
                        r_rem  <= r_dr;
                        r_ma   <= pt ? MW'(r_dq) : MW'(r_dq) + MW'(r_dr != '0);
                        r_mb   <= j_cq;
                        r_macc <= '0;
                        r_mcnt <= ($clog2(MW+1))'(MW);
                        r_state <= S_MUL;
                    end
                end
                S_MUL: begin
                    if (r_mcnt == '0) begin
                        r_resp <= sat_add(r_resp, prod_sat);
                        if (pt) begin
                            r_dq    <= DW'(r_rem) * DW'(j_n);
                            r_dr    <= '0;
                            r_dv    <= j_tq;
                            r_dcnt  <= ($clog2(DW+1))'(DW);
                            r_state <= S_CDIV;
                        end else begin
                            r_state <= S_NEXT;
                        end
                    end
                end
                S_CDIV: begin
                    if (r_dcnt == '0) begin
                        // ceil of remaining window arrivals
                        r_arr   <= (SPLIT_W+1)'(r_dq) + (SPLIT_W+1)'(r_dr != '0);
                        r_dq    <= DW'({r_rd.overload, {FRAC_BITS{1'b0}}});
                        r_dr    <= '0;
                        r_dv    <= QW'(j_n);
                        r_dcnt  <= ($clog2(DW+1))'(DW);
                        r_state <= S_NDIV;
                    end
                end
                S_NDIV: begin
                    if (r_dcnt == '0) begin
                        r_last  <= r_arr * r_dq[QW-1:0];
                        r_state <= S_LAST;
                    end
                end
                S_LAST: begin
                    r_resp  <= sat_add(r_resp, RW'(last_min));
                    r_state <= S_NEXT;
                end
                S_NEXT: begin
                    r_j     <= r_j + 1'b1;
                    r_state <= S_RJ;
                end
                S_COND: begin
                    if (r_resp > RW'(r_prev) && r_resp <= RW'(r_bound)) r_state <= S_ITER;
                    else r_state <= S_DONE;
                end
                S_DONE: begin
                    if (out_free) begin
                        r_ovalid <= 1'b1;
                        r_oresp  <= (r_resp > RW'(OUT_MAX)) ? OUT_MAX : r_resp[OUT_W-1:0];
                        r_osched <= r_resp <= RW'(r_final);
                        r_oans   <= 1'b1;
                        r_state  <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

`ifndef SYNTHESIS
    a_units_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(r_dcnt != '0 && r_mcnt != '0))
        else $error("divider and multiplier busy together");

    a_load_beat_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ovalid && !r_oans |-> r_oresp == '0 && !r_osched)
        else $error("load beat carries a response");

    a_j_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_JCHK |-> r_j < used)
        else $error("interferer index beyond table in use");

    a_done_to_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_DONE && out_free |=> r_state == S_IDLE && r_ovalid && r_oans)
        else $error("query result not delivered");
`endif

endmodule
`default_nettype wire
